// File: hw/rtl/modular_inverse_ext_euclid_assert.svh
// Assertion macros for the RTL of the modular inverse block.
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MIE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular inverse: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MIE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular inverse: next-cycle check failed");

`endif

// File: hw/rtl/mie_pkg.sv
package mie_pkg;

    localparam int WIDTH_DEF = 32;

    // Sequencer step addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_TEST   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DINIT  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DSTEP  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FIN    = 3'd5;

    // Datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP    = 3'd0;
    localparam op_t OP_LOAD   = 3'd1;
    localparam op_t OP_DINIT  = 3'd2;
    localparam op_t OP_DSTEP  = 3'd3;
    localparam op_t OP_UPDATE = 3'd4;
    localparam op_t OP_DONE   = 3'd5;

    // Jump conditions
    typedef logic [1:0] cond_t;
    localparam cond_t COND_ALWAYS   = 2'd0;
    localparam cond_t COND_START    = 2'd1;
    localparam cond_t COND_RN_ZERO  = 2'd2;
    localparam cond_t COND_CNT_LAST = 2'd3;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } uword_t;

    typedef struct packed {
        logic rn_zero;
        logic cnt_last;
    } status_t;

    // Microprogram: one control word per step
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        begin
            unique case (step)
                STEP_IDLE:   w = '{OP_LOAD,   COND_START,    STEP_TEST,   STEP_IDLE};
                STEP_TEST:   w = '{OP_NOP,    COND_RN_ZERO,  STEP_FIN,    STEP_DINIT};
                STEP_DINIT:  w = '{OP_DINIT,  COND_ALWAYS,   STEP_DSTEP,  STEP_DSTEP};
                STEP_DSTEP:  w = '{OP_DSTEP,  COND_CNT_LAST, STEP_UPDATE, STEP_DSTEP};
                STEP_UPDATE: w = '{OP_UPDATE, COND_ALWAYS,   STEP_TEST,   STEP_TEST};
                STEP_FIN:    w = '{OP_DONE,   COND_ALWAYS,   STEP_IDLE,   STEP_IDLE};
                default:     w = '{OP_NOP,    COND_ALWAYS,   STEP_IDLE,   STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// File: hw/rtl/mie_datapath.sv
module mie_datapath #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mie_pkg::op_t       op,
    input  logic [WIDTH-1:0]   value,
    input  logic [WIDTH-1:0]   modulus,
    output mie_pkg::status_t   status,
    output logic               done,
    output logic [WIDTH-1:0]   inverse,
    output logic               found
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] ro_reg, ro_next;
    logic [WIDTH-1:0] rn_reg, rn_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH:0]   co_reg, co_next;
    logic [WIDTH:0]   cn_reg, cn_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] dq_reg, dq_next;
    logic [WIDTH:0]   acc_reg, acc_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             par_reg, par_next;
    logic [WIDTH-1:0] inverse_reg, inverse_next;
    logic             found_reg, found_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;
    logic             qbit;
    logic [WIDTH:0]   red;
    logic [WIDTH-1:0] inv_val;
    logic             fnd;

    // One restoring division bit, with Horner accumulation of q * coef_new
    assign rem_sh = {rem_reg[WIDTH-1:0], dq_reg[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, rn_reg};
    assign qbit   = (rem_sh >= {1'b0, rn_reg});

    // Final reduction: coefficient never exceeds the modulus
    assign red     = (co_reg >= {1'b0, mod_reg}) ? (co_reg - {1'b0, mod_reg}) : co_reg;
    assign inv_val = (par_reg && (red != '0)) ? (mod_reg - red[WIDTH-1:0]) : red[WIDTH-1:0];
    assign fnd     = (ro_reg == WIDTH'(1)) && (mod_reg != '0);

    always_comb
    begin
        ro_next      = ro_reg;
        rn_next      = rn_reg;
        mod_next     = mod_reg;
        co_next      = co_reg;
        cn_next      = cn_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        par_next     = par_reg;
        inverse_next = inverse_reg;
        found_next   = found_reg;
        done_next    = 1'b0;
        unique case (op)
            mie_pkg::OP_LOAD:
            begin
                ro_next  = value;
                rn_next  = modulus;
                mod_next = modulus;
                co_next  = (WIDTH+1)'(1);
                cn_next  = '0;
                par_next = 1'b0;
            end
            mie_pkg::OP_DINIT:
            begin
                rem_next = '0;
                dq_next  = ro_reg;
                acc_next = '0;
                cnt_next = '0;
            end
            mie_pkg::OP_DSTEP:
            begin
                rem_next = qbit ? diff : rem_sh;
                dq_next  = {dq_reg[WIDTH-2:0], qbit};
                acc_next = {acc_reg[WIDTH-1:0], 1'b0} + (qbit ? cn_reg : '0);
                cnt_next = cnt_reg + CW'(1);
            end
            mie_pkg::OP_UPDATE:
            begin
                ro_next  = rn_reg;
                rn_next  = rem_reg[WIDTH-1:0];
                co_next  = cn_reg;
                cn_next  = co_reg + acc_reg;
                par_next = ~par_reg;
            end
            mie_pkg::OP_DONE:
            begin
                inverse_next = fnd ? inv_val : '0;
                found_next   = fnd;
                done_next    = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ro_reg      <= ro_next;
        rn_reg      <= rn_next;
        mod_reg     <= mod_next;
        co_reg      <= co_next;
        cn_reg      <= cn_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        par_reg     <= par_next;
        inverse_reg <= inverse_next;
        found_reg   <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign status.rn_zero  = (rn_reg == '0);
    assign status.cnt_last = (cnt_reg == CW'(WIDTH - 1));
    assign done    = done_reg;
    assign inverse = inverse_reg;
    assign found   = found_reg;

endmodule

// File: hw/rtl/modular_inverse_ext_euclid.sv
// Channel   Ports                     Handshake
// -------   -----------------------   -------------------------------------------
// input     value, modulus            item taken at clk edge with start & !busy
// result    inverse, found            valid for one cycle while done is high
//
// done rises after the accepting edge once the sequencer has run k Euclid
// steps (k at most about 1.44*WIDTH + 2); each step runs the bit-serial
// restoring divider, one quotient bit per cycle.
// rst_n clears the sequencer and the done strobe; working registers are not reset.
// busy stays high from the accepting edge until the result is registered.
// The receiver has no stall: the result shows once, in the cycle done is high.
module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] inverse,
    output logic             found
);

`include "modular_inverse_ext_euclid_assert.svh"

    logic [mie_pkg::STEP_W-1:0] step_reg, step_next;
    mie_pkg::uword_t            uw;
    mie_pkg::status_t           status;
    mie_pkg::op_t               op;
    logic                       take;

    // Fetch the control word for the current step
    assign uw = mie_pkg::ucode(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uw.cond)
            mie_pkg::COND_ALWAYS:   take = 1'b1;
            mie_pkg::COND_START:    take = start;
            mie_pkg::COND_RN_ZERO:  take = status.rn_zero;
            mie_pkg::COND_CNT_LAST: take = status.cnt_last;
            default:                take = 1'b1;
        endcase
    end

    assign step_next = take ? uw.tgt_true : uw.tgt_false;

    // Hold the load back until an item is actually accepted
    assign op = (uw.cond == mie_pkg::COND_START && !start) ? mie_pkg::OP_NOP : uw.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= mie_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign busy = (step_reg != mie_pkg::STEP_IDLE);

    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .value   (value),
        .modulus (modulus),
        .status  (status),
        .done    (done),
        .inverse (inverse),
        .found   (found)
    );

    // Result registers fill on the step that returns to idle
    `MIE_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // An accepted item occupies the sequencer on the next cycle
    `MIE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // No inverse means a zero result
    `MIE_ASSERT_NOW(a_none_zero, clk, rst_n, done && !found, inverse == '0)

endmodule

// File: test/modular_inverse_ext_euclid_checker.sv
module modular_inverse_ext_euclid_checker #(
    parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] modulus,
    input  logic             done,
    input  logic [WIDTH-1:0] inverse,
    input  logic             found,
    output int unsigned      mismatches,
    output int unsigned      pending,
    output int unsigned      checked,
    output int unsigned      inverses_found
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDE_W = 2*WIDTH + 2;

    typedef logic [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic             found;
    } inv_result_t;

    inv_result_t predicted_inverses[$];
    inv_result_t want;

    // Extended Euclid on (a, n); coefficient magnitudes only, the sign
    // alternates with each division step.
    function automatic inv_result_t predict_inverse(logic [WIDTH-1:0] a,
                                                    logic [WIDTH-1:0] n);
        wide_t       rem_prev;
        wide_t       rem_cur;
        wide_t       rem_next;
        wide_t       coef_prev;
        wide_t       coef_cur;
        wide_t       coef_next;
        wide_t       quo;
        wide_t       reduced;
        bit          odd_steps;
        inv_result_t res;
        res = '0;
        if (n == '0)
            return res;
        rem_prev  = wide_t'(a);
        rem_cur   = wide_t'(n);
        coef_prev = wide_t'(1);
        coef_cur  = '0;
        odd_steps = 1'b0;
        while (rem_cur != '0)
        begin
            quo       = rem_prev / rem_cur;
            rem_next  = rem_prev % rem_cur;
            coef_next = coef_prev + quo * coef_cur;
            rem_prev  = rem_cur;
            rem_cur   = rem_next;
            coef_prev = coef_cur;
            coef_cur  = coef_next;
            odd_steps = ~odd_steps;
        end
        if (rem_prev == wide_t'(1))
        begin
            reduced   = coef_prev % wide_t'(n);
            res.found = 1'b1;
            if (odd_steps && reduced != '0)
                res.inverse = n - reduced[WIDTH-1:0];
            else
                res.inverse = reduced[WIDTH-1:0];
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            predicted_inverses.delete();
            mismatches     = 0;
            pending        = 0;
            checked        = 0;
            inverses_found = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted_inverses = {predicted_inverses, predict_inverse(value, modulus)};
                pending++;
            end
            if (done)
            begin
                if (predicted_inverses.size() == 0)
                begin
                    $error("unexpected result: inverse %0d found %0d", inverse, found);
                    mismatches++;
                end
                else
                begin
                    want = predicted_inverses.pop_front();
                    pending--;
                    checked++;
                    if (want.found)
                        inverses_found++;
                    if (inverse !== want.inverse)
                    begin
                        $error("inverse: expected %0d, actual %0d", want.inverse, inverse);
                        mismatches++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, found);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// File: test/modular_inverse_ext_euclid_tb.sv
module modular_inverse_ext_euclid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = mie_pkg::WIDTH_DEF;

    // Budget: the slowest item, the longest Euclid run plus the widest gap,
    // allowed roughly three times over for every item.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // Quiet time after the last result to catch a stray strobe.
    localparam int unsigned TAIL_CYCLES = 2000;
    localparam int unsigned BURST_ITEMS = 70;
    localparam int unsigned GAPPY_ITEMS = 280;

    // A large prime and consecutive Fibonacci numbers (the longest Euclid runs).
    localparam logic [WIDTH-1:0] PRIME_TOP = 32'd4294967291;
    localparam logic [WIDTH-1:0] FIB_47    = 32'd2971215073;
    localparam logic [WIDTH-1:0] FIB_46    = 32'd1836311903;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             start   = 1'b0;
    logic [WIDTH-1:0] value   = '0;
    logic [WIDTH-1:0] modulus = '1;
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] inverse;
    logic             found;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;
    int unsigned inverses_found;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    always #1 clk = ~clk;

    modular_inverse_ext_euclid #(
        .WIDTH(WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .value  (value),
        .modulus(modulus),
        .done   (done),
        .inverse(inverse),
        .found  (found)
    );

    // The checker snoops both channels, predicts each accepted item and
    // compares the one-cycle result strobe against the oldest prediction.
    modular_inverse_ext_euclid_checker #(
        .WIDTH(WIDTH)
    ) result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .modulus       (modulus),
        .done          (done),
        .inverse       (inverse),
        .found         (found),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .inverses_found(inverses_found)
    );

    // Watchdog: a hung divider or a lost strobe ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. Called at a
    // rising edge; returns at the edge that accepted the item. start is only
    // dropped when a gap is drawn, so a back-to-back item keeps it high and
    // never gets two assignments in one step.
    task automatic send_item(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] n,
                             input bit allow_gap);
        int unsigned gap;
        bit          taken;
        gap = allow_gap ? $urandom_range(19, 0) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= a;
        modulus <= n;
        taken = 1'b0;
        // busy only moves at rising edges, so look at it mid-cycle.
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Draw one random operand pair from a mix of shapes: full-width noise,
    // tiny moduli, values above and below the modulus, a prime modulus, shared factors, edge values.
    task automatic random_operands(output logic [WIDTH-1:0] a, output logic [WIDTH-1:0] n);
        int unsigned shape;
        int unsigned factor;
        shape = $urandom_range(9, 0);
        a = $urandom;
        n = $urandom;
        case (shape)
            4:
            begin
                // tiny modulus, wide value: first step reduces the value
                n = $urandom_range(64, 1);
            end
            5:
            begin
                // random-size modulus, value below it
                n = $urandom >> $urandom_range(WIDTH - 1, 0);
                if (n == '0)
                    n = 1;
                a = $urandom % n;
            end
            6:
            begin
                // prime modulus: nearly always invertible
                n = PRIME_TOP;
            end
            7:
            begin
                // shared factor: no inverse
                factor = $urandom_range(1000, 2);
                a = factor * $urandom_range(4_000_000, 0);
                n = factor * $urandom_range(4_000_000, 1);
            end
            8:
            begin
                // edge values of the value against a random modulus
                if (n < 2)
                    n = 2;
                case ($urandom_range(4, 0))
                    0:       a = '0;
                    1:       a = 1;
                    2:       a = n - 1;
                    3:       a = n;
                    default: a = '1;
                endcase
            end
            9:
            begin
                // modulus of one or two
                n = $urandom_range(2, 1);
            end
            default:
            begin
                // full-width noise
            end
        endcase
        if (n == '0)
            n = 1;
    endtask

    task automatic send_random(input int unsigned count, input bit allow_gap);
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] n;
        repeat (count)
        begin
            random_operands(a, n);
            send_item(a, n, allow_gap);
        end
    endtask

    initial
    begin
        // Hold reset from time zero, then release it on a rising edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, with gaps.
        send_item('0, 1, 1'b1);                    // modulus of one, value zero
        send_item(5, 1, 1'b1);                     // modulus of one, small value
        send_item('1, 1, 1'b1);                    // modulus of one, value all ones
        send_item('0, 7, 1'b1);                    // value zero: gcd is the modulus
        send_item('0, '1, 1'b1);                   // value zero, widest modulus
        send_item(1, '1, 1'b1);                    // inverse of one
        send_item('1, '1, 1'b1);                   // value equals modulus
        send_item('1 - 1, '1, 1'b1);               // minus one mod n
        send_item(3, 7, 1'b1);
        send_item(10, 7, 1'b1);                    // value above modulus
        send_item(7, 7, 1'b1);
        send_item(2, 4, 1'b1);                     // common factor two
        send_item('1, 2, 1'b1);
        send_item(1, 2, 1'b1);
        send_item(FIB_46, FIB_47, 1'b1);           // longest Euclid chain
        send_item(FIB_47, FIB_46, 1'b1);           // same chain, value on top
        send_item(32'h8000_0000, '1, 1'b1);        // top bit alone
        send_item(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send_item(2, PRIME_TOP, 1'b1);
        send_item('1, PRIME_TOP, 1'b1);            // value above a prime modulus
        send_item(PRIME_TOP - 1, PRIME_TOP, 1'b1);

        // Back-to-back stretch: start stays high, no gaps.
        send_random(BURST_ITEMS, 1'b0);
        // Random gaps on every item for the rest.
        send_random(GAPPY_ITEMS, 1'b1);

        start <= 1'b0;

        // Drain: let the checker log the last item, wait for every predicted
        // result, then listen a while longer.
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items: directed corners, a back-to-back burst and gapped random mixes.",
                 items_sent);
        $display("Checked %0d results: %0d with an inverse, %0d without.",
                 checked, inverses_found, checked - inverses_found);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
